/* src/hvd_pkg.sv */
// Shared types, constants and saturating arithmetic for the two-state Viterbi decoder.
// No dependencies; imported by hmm_viterbi_decoder.
`default_nettype none

package hvd_pkg;

	localparam int Q_W             = 24;  // signed Q15.8 score width
	localparam int POS_W           = 6;   // width of the position field
	localparam int CFG_IDX_W       = 3;
	localparam int NUM_CFG         = 6;
	localparam int MAX_SEQ_LEN_DEF = 64;

	localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
	localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INIT0   = 3'd0,
		REG_INIT1   = 3'd1,
		REG_TRANS00 = 3'd2,
		REG_TRANS01 = 3'd3,
		REG_TRANS10 = 3'd4,
		REG_TRANS11 = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CAND,
		ST_SEL,
		ST_NORM,
		ST_TB_READ,
		ST_TB_OUT
	} hvd_state_t;

	typedef struct packed {
		logic signed [Q_W-1:0] log_emit_state0;
		logic signed [Q_W-1:0] log_emit_state1;
		logic                  seq_last;
	} in_item_t;

	typedef struct packed {
		logic             decoded_state;
		logic [POS_W-1:0] position;
		logic             run_last;
	} out_item_t;

	// saturating a + b
	function automatic logic signed [Q_W-1:0] sat_add(input logic signed [Q_W-1:0] a,
	                                                  input logic signed [Q_W-1:0] b);
		logic signed [Q_W:0] s;
		s = {a[Q_W-1], a} + {b[Q_W-1], b};
		if (s[Q_W] != s[Q_W-1])
			return s[Q_W] ? Q_MIN : Q_MAX;
		return s[Q_W-1:0];
	endfunction

	// saturating a - b
	function automatic logic signed [Q_W-1:0] sat_sub(input logic signed [Q_W-1:0] a,
	                                                  input logic signed [Q_W-1:0] b);
		logic signed [Q_W:0] s;
		s = {a[Q_W-1], a} - {b[Q_W-1], b};
		if (s[Q_W] != s[Q_W-1])
			return s[Q_W] ? Q_MIN : Q_MAX;
		return s[Q_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* src/hmm_viterbi_decoder.sv */
// Top level of the two-state log-domain Viterbi decoder with survivor memory and traceback.
// Depends on hvd_pkg (types, register codes, saturating add/subtract).
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------------
//  in      | sink      | in_valid / in_ready   | in_data  (emission scores, seq_last)
//  out     | source    | out_valid / out_ready | out_data (decoded_state, position, run_last)
//  cfg     | sink      | cfg_wr_en             | cfg_index, cfg_wdata (no wait, no read-back)
//
// An observation passes through transfer, candidate sums, compare-select plus emission,
// then renormalise plus survivor write; the next one is taken in the cycle after.
// On the last observation the traceback follows: each result takes a survivor memory
// read, then presentation, as the survivor memory is read through a register.
// Reset clears the configuration registers, path metrics, step counter and controller;
// the survivor memory is not cleared, as traceback only reads entries of the current run.
// A stalled out_ready holds the traceback; no input is taken until it has finished.
`default_nettype none

module hmm_viterbi_decoder #(
	parameter int MAX_SEQ_LEN = hvd_pkg::MAX_SEQ_LEN_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// observation channel
	input  wire logic                           in_valid,
	output      logic                           in_ready,
	input  wire hvd_pkg::in_item_t              in_data,
	// result channel
	output      logic                           out_valid,
	input  wire logic                           out_ready,
	output      hvd_pkg::out_item_t             out_data,
	// configuration writes
	input  wire logic                           cfg_wr_en,
	input  wire logic [hvd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [hvd_pkg::Q_W-1:0]        cfg_wdata
);
	import hvd_pkg::*;

	localparam int PosW = $clog2(MAX_SEQ_LEN);
	localparam logic [PosW-1:0] LastPos = PosW'(MAX_SEQ_LEN - 1);

	hvd_state_t state_q, state_d;

	// configuration
	logic signed [Q_W-1:0] init0_q, init1_q;
	logic signed [Q_W-1:0] trans00_q, trans01_q, trans10_q, trans11_q;

	// latched observation
	logic signed [Q_W-1:0] emit0_q, emit1_q;
	logic                  seq_last_q;

	// add-compare-select pipeline (one item in flight)
	logic signed [Q_W-1:0] cand00_s1, cand01_s1, cand10_s1, cand11_s1;
	logic signed [Q_W-1:0] nm0_s2, nm1_s2;
	logic [1:0]            surv_s2;

	logic signed [Q_W-1:0] pm0_q, pm1_q;
	logic [PosW-1:0]       step_q;

	// traceback
	logic            tb_state_q;
	logic [PosW-1:0] tb_pos_q;
	logic [1:0]      surv_rd_q;

	// survivor store: bit k = chosen predecessor of state k at that position
	logic [1:0] surv_mem [MAX_SEQ_LEN];

	logic first_pos;
	logic last_item;
	logic tb_done;
	logic signed [Q_W-1:0] sel0, sel1, best;

	assign first_pos = (step_q == '0);
	assign last_item = seq_last_q || (step_q == LastPos);
	assign tb_done   = (tb_pos_q == '0);

	// compare-select; state 0 wins a tie
	assign sel0 = (cand10_s1 > cand00_s1) ? cand10_s1 : cand00_s1;
	assign sel1 = (cand11_s1 > cand01_s1) ? cand11_s1 : cand01_s1;
	assign best = (nm1_s2 > nm0_s2) ? nm1_s2 : nm0_s2;

	// controller
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = ST_CAND;
			end
			ST_CAND: state_d = ST_SEL;
			ST_SEL:  state_d = ST_NORM;
			ST_NORM: state_d = last_item ? ST_TB_READ : ST_IDLE;
			ST_TB_READ: state_d = ST_TB_OUT;
			ST_TB_OUT: begin
				out_valid = 1'b1;
				if (out_ready)
					state_d = tb_done ? ST_IDLE : ST_TB_READ;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// configuration registers; indexes beyond the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init0_q   <= '0;
			init1_q   <= '0;
			trans00_q <= '0;
			trans01_q <= '0;
			trans10_q <= '0;
			trans11_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_INIT0:   init0_q   <= cfg_wdata;
				REG_INIT1:   init1_q   <= cfg_wdata;
				REG_TRANS00: trans00_q <= cfg_wdata;
				REG_TRANS01: trans01_q <= cfg_wdata;
				REG_TRANS10: trans10_q <= cfg_wdata;
				REG_TRANS11: trans11_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// payload registers: observation, ACS stages, traceback
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			emit0_q    <= in_data.log_emit_state0;
			emit1_q    <= in_data.log_emit_state1;
			seq_last_q <= in_data.seq_last;
		end
		if (state_q == ST_CAND) begin
			// first position: initial scores plus emission go straight through
			cand00_s1 <= first_pos ? sat_add(init0_q, emit0_q) : sat_add(pm0_q, trans00_q);
			cand01_s1 <= first_pos ? sat_add(init1_q, emit1_q) : sat_add(pm0_q, trans01_q);
			cand10_s1 <= sat_add(pm1_q, trans10_q);
			cand11_s1 <= sat_add(pm1_q, trans11_q);
		end
		if (state_q == ST_SEL) begin
			nm0_s2  <= first_pos ? cand00_s1 : sat_add(sel0, emit0_q);
			nm1_s2  <= first_pos ? cand01_s1 : sat_add(sel1, emit1_q);
			surv_s2 <= {cand11_s1 > cand01_s1, cand10_s1 > cand00_s1};
		end
		if (state_q == ST_NORM && last_item) begin
			tb_state_q <= (nm1_s2 > nm0_s2);
			tb_pos_q   <= step_q;
		end
		if (state_q == ST_TB_OUT && out_ready && !tb_done) begin
			tb_state_q <= surv_rd_q[tb_state_q];
			tb_pos_q   <= tb_pos_q - 1'b1;
		end
	end

	// path metrics and position counter; both return to zero after a run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm0_q  <= '0;
			pm1_q  <= '0;
			step_q <= '0;
		end else if (state_q == ST_NORM) begin
			if (last_item) begin
				pm0_q  <= '0;
				pm1_q  <= '0;
				step_q <= '0;
			end else begin
				pm0_q  <= sat_sub(nm0_s2, best);
				pm1_q  <= sat_sub(nm1_s2, best);
				step_q <= step_q + 1'b1;
			end
		end
	end

	// survivor memory: written once per non-first position, read at the traceback pointer
	always_ff @(posedge clk) begin
		if (state_q == ST_NORM && !first_pos)
			surv_mem[step_q] <= surv_s2;
		surv_rd_q <= surv_mem[tb_pos_q];
	end

	assign out_data.decoded_state = tb_state_q;
	assign out_data.position      = POS_W'(tb_pos_q);
	assign out_data.run_last      = tb_done;

endmodule

`default_nettype wire

/* bench/tb_hmm_viterbi_decoder.sv */
// Self-checking bench for the two-state log-domain Viterbi decoder: directed sequences,
// then random sequences under three idling patterns, all checked against a local predictor.
// Depends on hvd_pkg (payload structs, register codes, widths) and hmm_viterbi_decoder.

module tb_hmm_viterbi_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import hvd_pkg::*;

	localparam int MAX_LEN = MAX_SEQ_LEN_DEF;

	// Tracks path metrics and survivor decisions as observations are transferred in,
	// and holds the decoded states still owed by the block, oldest first.
	class viterbi_ledger;
		logic signed [Q_W-1:0] log_init[2];
		logic signed [Q_W-1:0] log_trans[2][2];  // [from][to]
		longint                metric[2];
		logic [1:0]            surv[MAX_LEN];
		int                    step;
		out_item_t             owed_states[$];
		int                    n_obs, n_seq, n_checked, n_err;

		function new();
			for (int k = 0; k < 2; k++) begin
				log_init[k] = '0;
				log_trans[k][0] = '0;
				log_trans[k][1] = '0;
				metric[k] = 0;
			end
			step = 0;
			n_obs = 0;
			n_seq = 0;
			n_checked = 0;
			n_err = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] val);
			case (idx)
				REG_INIT0:   log_init[0] = val;
				REG_INIT1:   log_init[1] = val;
				REG_TRANS00: log_trans[0][0] = val;
				REG_TRANS01: log_trans[0][1] = val;
				REG_TRANS10: log_trans[1][0] = val;
				REG_TRANS11: log_trans[1][1] = val;
				default: ;  // unmapped index: ignored
			endcase
		endfunction

		static function longint clip(longint v);
			if (v < longint'(Q_MIN))
				return longint'(Q_MIN);
			if (v > longint'(Q_MAX))
				return longint'(Q_MAX);
			return v;
		endfunction

		function void take_obs(in_item_t it);
			longint    emit[2], nm[2];
			longint    c0, c1, m, best;
			logic [1:0] sv;
			int        pos;
			bit        last;
			logic      s;
			out_item_t r;
			emit[0] = longint'($signed(it.log_emit_state0));
			emit[1] = longint'($signed(it.log_emit_state1));
			pos = (step > MAX_LEN - 1) ? MAX_LEN - 1 : step;
			n_obs++;
			if (pos == 0) begin
				for (int k = 0; k < 2; k++)
					nm[k] = clip(longint'(log_init[k]) + emit[k]);
			end else begin
				sv = '0;
				for (int k = 0; k < 2; k++) begin
					c0 = clip(metric[0] + longint'(log_trans[0][k]));
					c1 = clip(metric[1] + longint'(log_trans[1][k]));
					m = c0;
					if (c1 > c0) begin  // state 0 keeps a tie
						m = c1;
						sv[k] = 1'b1;
					end
					nm[k] = clip(m + emit[k]);
				end
				surv[pos] = sv;
			end
			best = (nm[0] > nm[1]) ? nm[0] : nm[1];
			metric[0] = clip(nm[0] - best);
			metric[1] = clip(nm[1] - best);
			last = it.seq_last || (pos >= MAX_LEN - 1);
			if (!last) begin
				step = pos + 1;
				return;
			end
			// traceback, last position first
			s = (metric[1] > metric[0]);
			for (int p = pos; p >= 0; p--) begin
				r.decoded_state = s;
				r.position = p[POS_W-1:0];
				r.run_last = (p == 0);
				owed_states.push_back(r);
				if (p > 0)
					s = surv[p][s];
			end
			step = 0;
			metric[0] = 0;
			metric[1] = 0;
			n_seq++;
		endfunction

		function void field_cmp(string name, int want, int got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				n_err++;
			end
		endfunction

		function void check_state(out_item_t got);
			out_item_t want;
			if (owed_states.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual state %0d position %0d last %0d",
				         $time, got.decoded_state, got.position, got.run_last);
				n_err++;
				return;
			end
			want = owed_states.pop_front();
			n_checked++;
			field_cmp("decoded_state", want.decoded_state, got.decoded_state);
			field_cmp("position", want.position, got.position);
			field_cmp("run_last", want.run_last, got.run_last);
		endfunction

		function int pending();
			return owed_states.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_item_t            out_data;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [Q_W-1:0]       cfg_wdata;

	viterbi_ledger ledger;
	int            send_idle_pct;
	int            recv_idle_pct;

	hmm_viterbi_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver: out_ready redrawn at every falling edge, so stalls land on every
	// phase of the traceback.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Result monitor: a transfer is valid and ready at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ledger.check_state(out_data);
	end

	// Score for an emission or a register: extremes, zero, small values near the
	// decision points, and full-width noise so that every bit toggles.
	function automatic logic [Q_W-1:0] rand_score();
		int t;
		case ($urandom_range(0, 5))
			0: return Q_MIN;
			1: return Q_MAX;
			2, 3: begin
				t = $urandom_range(0, 8191) - 4096;
				return t[Q_W-1:0];
			end
			4: return '0;
			default: return Q_W'($urandom());
		endcase
	endfunction

	function automatic in_item_t obs(logic [Q_W-1:0] e0, logic [Q_W-1:0] e1, logic last);
		in_item_t it;
		it.log_emit_state0 = e0;
		it.log_emit_state1 = e1;
		it.seq_last = last;
		return it;
	endfunction

	// One observation transfer. Valid stays high afterwards; the next call or a
	// pause lowers or reloads it at the following falling edge.
	task automatic send_obs(in_item_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		ledger.take_obs(it);
	endtask

	// Register write: one cycle with the enable high.
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		ledger.write_reg(idx, val);
	endtask

	// Stop sending, wait for every owed state, then let the pipeline settle.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (ledger.pending() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Sequence of random scores; the final item carries the given seq_last.
	task automatic send_seq(int len, logic end_flag);
		for (int i = 0; i < len; i++)
			send_obs(obs(rand_score(), rand_score(), (i == len - 1) ? end_flag : 1'b0));
	endtask

	task automatic random_config();
		cfg_write(REG_INIT0, rand_score());
		cfg_write(REG_INIT1, rand_score());
		cfg_write(REG_TRANS00, rand_score());
		cfg_write(REG_TRANS01, rand_score());
		cfg_write(REG_TRANS10, rand_score());
		cfg_write(REG_TRANS11, rand_score());
		if ($urandom_range(0, 1))
			cfg_write(CFG_IDX_W'(NUM_CFG + $urandom_range(0, 1)), Q_W'($urandom()));
	endtask

	// Guard against a hung handshake.
	initial begin
		#2000000;
		$display("[hmm_viterbi_decoder] ERROR");
		$finish;
	end

	initial begin
		int sent;
		ledger = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		send_idle_pct = 19;
		recv_idle_pct = 49;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed part ---
		// Reset configuration: single observations, one clear winner and one tie.
		send_obs(obs(Q_MIN, Q_MAX, 1'b1));
		send_obs(obs('0, '0, 1'b1));
		settle();

		// All registers at the extremes; unmapped indexes must be ignored.
		cfg_write(REG_INIT0, Q_MAX);
		cfg_write(REG_INIT1, Q_MAX);
		cfg_write(REG_TRANS00, Q_MIN);
		cfg_write(REG_TRANS01, Q_MAX);
		cfg_write(REG_TRANS10, Q_MAX);
		cfg_write(REG_TRANS11, Q_MIN);
		cfg_write(CFG_IDX_W'(NUM_CFG), 24'h5A5A5A);
		cfg_write(CFG_IDX_W'(NUM_CFG + 1), 24'hA5A5A5);
		// saturating sums, then ties after renormalisation
		send_obs(obs(Q_MAX, Q_MIN, 1'b0));
		send_obs(obs(Q_MIN, Q_MAX, 1'b0));
		send_obs(obs('0, '0, 1'b0));
		send_obs(obs(Q_MAX, Q_MAX, 1'b1));
		send_obs(obs(Q_MIN, Q_MIN, 1'b1));
		settle();

		// Realistic small log probabilities, state 1 unreachable at start and
		// the 1->0 transition at log(0).
		cfg_write(REG_INIT0, '0);
		cfg_write(REG_INIT1, Q_MIN);
		cfg_write(REG_TRANS00, -24'sd256);
		cfg_write(REG_TRANS01, -24'sd1024);
		cfg_write(REG_TRANS10, Q_MIN);
		cfg_write(REG_TRANS11, -24'sd64);
		send_obs(obs(-24'sd512, -24'sd128, 1'b0));
		send_obs(obs(-24'sd2048, '0, 1'b0));
		send_obs(obs('0, -24'sd3000, 1'b0));
		send_obs(obs(-24'sd100, -24'sd100, 1'b0));
		send_obs(obs(Q_MIN, '0, 1'b0));
		send_obs(obs('0, Q_MIN, 1'b1));
		send_obs(obs(-24'sd700, -24'sd10, 1'b0));
		send_obs(obs(-24'sd10, -24'sd700, 1'b1));
		settle();

		// --- random part: three idling patterns, fresh configuration each ---
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 19;
					recv_idle_pct = 49;
				end
				1: begin
					send_idle_pct = 49;
					recv_idle_pct = 19;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			random_config();
			// full survivor store: ends on its own without seq_last
			if (ph == 2)
				send_seq(MAX_LEN, 1'b0);
			sent = 0;
			while (sent < 6) begin
				int len;
				len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 10);
				send_seq(len, 1'b1);
				sent += len;
				// sender holds off until the block has delivered everything
				if ($urandom_range(0, 4) == 0)
					settle();
			end
			settle();
		end

		$display("covered %0d observations in %0d sequences, %0d decoded states compared",
		         ledger.n_obs, ledger.n_seq, ledger.n_checked);
		$display("registers at extremes and random values, unmapped writes, a full-store run");
		if (ledger.n_err == 0 && ledger.pending() == 0) begin
			$display("[hmm_viterbi_decoder] OK");
		end else begin
			$display("[hmm_viterbi_decoder] ERROR");
		end
		$finish;
	end

endmodule

/* files.f */
src/hvd_pkg.sv
src/hmm_viterbi_decoder.sv
bench/tb_hmm_viterbi_decoder.sv
